// ----- rtl/pte_pkg.sv -----
// Package for the page table engine: command and status codes, transaction
// structs and default sizes. Used by rtl/page_table_engine.sv.
// Depends on nothing else.
package pte_pkg;

  localparam int PAGE_SLOTS_DEF = 256;
  localparam int FRAME_BITS_DEF = 16;

  localparam int CMD_W    = 4;
  localparam int PAGE_W   = 16;
  localparam int FRAME_W  = 16;
  localparam int STATUS_W = 2;
  localparam int TALLY_W  = 9;

  localparam logic [TALLY_W-1:0] TALLY_MAX    = '1;
  localparam logic [TALLY_W-1:0] PAGES_RESET  = 9'd256;

  localparam logic [CMD_W-1:0] CMD_MAP       = 4'd0;
  localparam logic [CMD_W-1:0] CMD_UNMAP     = 4'd1;
  localparam logic [CMD_W-1:0] CMD_TRANSLATE = 4'd2;
  localparam logic [CMD_W-1:0] CMD_READ      = 4'd3;
  localparam logic [CMD_W-1:0] CMD_SET_REF   = 4'd4;
  localparam logic [CMD_W-1:0] CMD_SET_DIRTY = 4'd5;
  localparam logic [CMD_W-1:0] CMD_CLR_REF   = 4'd6;
  localparam logic [CMD_W-1:0] CMD_CLEAR_ALL = 4'd7;
  localparam logic [CMD_W-1:0] CMD_COUNT     = 4'd8;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SEGV    = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [PAGE_W-1:0]  virtual_page;
    logic [FRAME_W-1:0] frame_number;
    logic               flag_value;
  } pte_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [FRAME_W-1:0]  frame_out;
    logic                present_out;
    logic                dirty_out;
    logic                referenced_out;
    logic [TALLY_W-1:0]  present_total;
  } pte_out_t;

endpackage

// ----- rtl/page_table_engine.sv -----
// Page table engine top level: entry memory, live bits, present count.
// Depends on rtl/pte_pkg.sv for codes, transaction structs and defaults.
//
// Usage: a command transaction is taken at a clock edge with start high and
// busy low; its fields arrive on in_data. One result per command appears on
// out_data for exactly one cycle while out_valid is high; the receiver cannot
// stall, so results are never held. A command taken at issue is held in the
// stage registers while its entry is read, and its result is then registered
// into out_data; a new command may be issued at every edge while busy is
// low, for a throughput of one command per cycle. The entry memory has one
// synchronous read port, read at issue, and one write port, written in the
// cycle after; a command that reads the entry the previous command just
// wrote takes the data from a last-write register. Clear all drops every
// live bit, so an entry not written since reads as all zero. cfg_wdata,
// written when cfg_we is high, sets how many pages are valid; the user must
// change it only while no command is in flight, which the block does not
// check. Reset (synchronous, rst_n low) clears the live bits, the present
// count and the pipeline, sets the page count to 256 and holds busy high.
module page_table_engine #(
  parameter int PAGE_SLOTS = pte_pkg::PAGE_SLOTS_DEF,
  parameter int FRAME_BITS = pte_pkg::FRAME_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  pte_pkg::pte_in_t              in_data,
  output logic                          out_valid,
  output pte_pkg::pte_out_t             out_data,
  input  logic                          cfg_we,
  input  logic [pte_pkg::TALLY_W-1:0]   cfg_wdata
);

  localparam int IDX_W = (PAGE_SLOTS > 1) ? $clog2(PAGE_SLOTS) : 1;
  localparam int E_W   = FRAME_BITS + 3;
  localparam int P_BIT = FRAME_BITS;
  localparam int D_BIT = FRAME_BITS + 1;
  localparam int R_BIT = FRAME_BITS + 2;
  localparam logic [pte_pkg::PAGE_W:0] SLOT_LIMIT = (pte_pkg::PAGE_W + 1)'(PAGE_SLOTS);

  logic [E_W-1:0]                 mem [PAGE_SLOTS];
  logic [E_W-1:0]                 rdata_r;
  logic [PAGE_SLOTS-1:0]          live_r;

  logic                           busy_r;
  logic [pte_pkg::TALLY_W-1:0]    pages_r;
  logic [pte_pkg::TALLY_W-1:0]    tally_r;
  logic [pte_pkg::TALLY_W-1:0]    tally_nxt;

  logic                           s_valid_r;
  logic [pte_pkg::CMD_W-1:0]      s_cmd_r;
  logic [pte_pkg::PAGE_W-1:0]     s_page_r;
  logic [FRAME_BITS-1:0]          s_frame_r;
  logic                           s_flag_r;

  logic                           lw_valid_r;
  logic [IDX_W-1:0]               lw_idx_r;
  logic [E_W-1:0]                 lw_data_r;

  logic                           out_valid_r;
  pte_pkg::pte_out_t              out_data_r;
  pte_pkg::pte_out_t              out_data_nxt;

  logic                           accept;
  logic [IDX_W-1:0]               s_idx;
  logic                           in_range;
  logic [E_W-1:0]                 raw_entry;
  logic [E_W-1:0]                 cur_entry;
  logic                           was_present;
  logic                           wr_en;
  logic [E_W-1:0]                 wr_data;
  logic                           clr_all;

  assign accept    = start && !busy_r;
  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign s_idx    = s_page_r[IDX_W-1:0];
  assign in_range = ((pte_pkg::PAGE_W + 1)'(s_page_r) < (pte_pkg::PAGE_W + 1)'(pages_r)) &&
                    ((pte_pkg::PAGE_W + 1)'(s_page_r) < SLOT_LIMIT);

  assign raw_entry   = (lw_valid_r && lw_idx_r == s_idx) ? lw_data_r : rdata_r;
  assign cur_entry   = live_r[s_idx] ? raw_entry : '0;
  assign was_present = cur_entry[P_BIT];

  always_comb begin
    wr_en        = 1'b0;
    wr_data      = cur_entry;
    clr_all      = 1'b0;
    tally_nxt    = tally_r;
    out_data_nxt = '0;
    out_data_nxt.status = pte_pkg::ST_OK;
    if (s_valid_r) begin
      if (s_cmd_r <= pte_pkg::CMD_CLR_REF) begin
        if (!in_range) begin
          out_data_nxt.status = pte_pkg::ST_INVALID;
        end else begin
          unique case (s_cmd_r)
            pte_pkg::CMD_MAP: begin
              wr_en                = 1'b1;
              wr_data              = '0;
              wr_data[FRAME_BITS-1:0] = s_frame_r;
              wr_data[P_BIT]       = 1'b1;
              wr_data[R_BIT]       = 1'b1;
              if (!was_present && tally_r != pte_pkg::TALLY_MAX) begin
                tally_nxt = tally_r + 1'b1;
              end
            end
            pte_pkg::CMD_UNMAP: begin
              wr_en   = 1'b1;
              wr_data = '0;
              if (was_present && tally_r != '0) begin
                tally_nxt = tally_r - 1'b1;
              end
            end
            pte_pkg::CMD_TRANSLATE: begin
              if (!was_present) begin
                out_data_nxt.status = pte_pkg::ST_SEGV;
              end else begin
                out_data_nxt.frame_out =
                  pte_pkg::FRAME_W'(cur_entry[FRAME_BITS-1:0]);
              end
            end
            pte_pkg::CMD_READ: begin
              out_data_nxt.frame_out =
                pte_pkg::FRAME_W'(cur_entry[FRAME_BITS-1:0]);
              out_data_nxt.present_out    = cur_entry[P_BIT];
              out_data_nxt.dirty_out      = cur_entry[D_BIT];
              out_data_nxt.referenced_out = cur_entry[R_BIT];
            end
            pte_pkg::CMD_SET_REF: begin
              wr_en          = 1'b1;
              wr_data[R_BIT] = s_flag_r;
            end
            pte_pkg::CMD_SET_DIRTY: begin
              wr_en          = 1'b1;
              wr_data[D_BIT] = s_flag_r;
            end
            default: begin
              wr_en          = 1'b1;
              wr_data[R_BIT] = 1'b0;
            end
          endcase
        end
      end else if (s_cmd_r == pte_pkg::CMD_CLEAR_ALL) begin
        clr_all   = 1'b1;
        tally_nxt = '0;
      end
    end
    out_data_nxt.present_total = tally_nxt;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rdata_r <= mem[in_data.virtual_page[IDX_W-1:0]];
    end
    if (wr_en) begin
      mem[s_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_cmd_r   <= in_data.cmd;
      s_page_r  <= in_data.virtual_page;
      s_frame_r <= FRAME_BITS'(in_data.frame_number);
      s_flag_r  <= in_data.flag_value;
    end
    if (wr_en) begin
      lw_idx_r  <= s_idx;
      lw_data_r <= wr_data;
    end
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b1;
      pages_r     <= pte_pkg::PAGES_RESET;
      tally_r     <= '0;
      live_r      <= '0;
      s_valid_r   <= 1'b0;
      lw_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= 1'b0;
      tally_r     <= tally_nxt;
      s_valid_r   <= accept;
      out_valid_r <= s_valid_r;
      if (cfg_we) begin
        pages_r <= cfg_wdata;
      end
      if (wr_en) begin
        lw_valid_r    <= 1'b1;
        live_r[s_idx] <= 1'b1;
      end
      if (clr_all) begin
        live_r <= '0;
      end
    end
  end

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for page_table_engine: drives command transactions,
// mirrors the page table in a small class and checks each result in order.
// Depends on rtl/pte_pkg.sv and rtl/page_table_engine.sv.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pte_pkg::*;

  class page_table_mirror;
    typedef struct packed {
      logic               referenced;
      logic               dirty;
      logic               present;
      logic [FRAME_W-1:0] frame;
    } slot_t;

    slot_t              slots[PAGE_SLOTS_DEF];
    bit                 live[PAGE_SLOTS_DEF];
    logic [TALLY_W-1:0] present_count;
    logic [TALLY_W-1:0] page_limit;
    pte_out_t           awaited_results[$];
    int unsigned        mismatches;

    function new();
      foreach (live[i]) begin
        live[i] = 1'b0;
        slots[i] = '0;
      end
      present_count = '0;
      page_limit = PAGES_RESET;
      mismatches = 0;
    endfunction

    function int unsigned page_bound();
      return (page_limit < PAGE_SLOTS_DEF) ? page_limit : PAGE_SLOTS_DEF;
    endfunction

    function void set_pages(logic [TALLY_W-1:0] value);
      page_limit = value;
    endfunction

    function int unsigned outstanding();
      return awaited_results.size();
    endfunction

    function void put_slot(int unsigned idx, slot_t value);
      slots[idx] = value;
      live[idx] = 1'b1;
    endfunction

    function void note_command(pte_in_t t);
      pte_out_t    r;
      slot_t       e;
      int unsigned idx;
      r = '0;
      idx = 32'(t.virtual_page);
      if (t.cmd <= CMD_CLR_REF) begin
        if (idx >= page_bound()) begin
          r.status = ST_INVALID;
        end else begin
          e = live[idx] ? slots[idx] : '0;
          case (t.cmd)
            CMD_MAP: begin
              if (!e.present && present_count < TALLY_MAX) present_count++;
              put_slot(idx, {1'b1, 1'b0, 1'b1, t.frame_number});
            end
            CMD_UNMAP: begin
              if (e.present && present_count > 0) present_count--;
              put_slot(idx, '0);
            end
            CMD_TRANSLATE: begin
              if (!e.present) r.status = ST_SEGV;
              else r.frame_out = e.frame;
            end
            CMD_READ: begin
              r.frame_out = e.frame;
              r.present_out = e.present;
              r.dirty_out = e.dirty;
              r.referenced_out = e.referenced;
            end
            CMD_SET_REF: begin
              e.referenced = t.flag_value;
              put_slot(idx, e);
            end
            CMD_SET_DIRTY: begin
              e.dirty = t.flag_value;
              put_slot(idx, e);
            end
            default: begin
              e.referenced = 1'b0;
              put_slot(idx, e);
            end
          endcase
        end
      end else if (t.cmd == CMD_CLEAR_ALL) begin
        foreach (live[i]) live[i] = 1'b0;
        present_count = '0;
      end
      r.present_total = present_count;
      awaited_results.push_back(r);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(pte_out_t got);
      pte_out_t want;
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        mismatches++;
        return;
      end
      want = awaited_results.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("frame_out", want.frame_out, got.frame_out);
      compare_field("present_out", want.present_out, got.present_out);
      compare_field("dirty_out", want.dirty_out, got.dirty_out);
      compare_field("referenced_out", want.referenced_out, got.referenced_out);
      compare_field("present_total", want.present_total, got.present_total);
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  pte_in_t            in_data = '0;
  logic               out_valid;
  pte_out_t           out_data;
  logic               cfg_we = 1'b0;
  logic [TALLY_W-1:0] cfg_wdata = '0;

  page_table_mirror mirror = new();
  int unsigned      issued = 0;

  page_table_engine dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) mirror.check_result(out_data);
      if (start && !busy) mirror.note_command(in_data);
    end
  end

  function automatic pte_in_t make_cmd(logic [CMD_W-1:0] cmd, int unsigned page,
                                       int unsigned frame, bit flag);
    pte_in_t t;
    t.cmd = cmd;
    t.virtual_page = PAGE_W'(page);
    t.frame_number = FRAME_W'(frame);
    t.flag_value = flag;
    return t;
  endfunction

  task automatic send(pte_in_t t, bit idle);
    if (idle && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    start <= 1'b1;
    in_data <= t;
    @(posedge clk);
    while (busy) @(posedge clk);
    issued++;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (mirror.outstanding() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_pages(logic [TALLY_W-1:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    mirror.set_pages(value);
  endtask

  function automatic int unsigned pick_page(int unsigned bound);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (bound > 0 && r < 60) return $urandom_range(0, ((bound < 24) ? bound : 24) - 1);
    if (bound > 0 && r < 80) return $urandom_range(0, bound - 1);
    if (r < 90) return bound + $urandom_range(0, 3);
    return $urandom_range(0, 65535);
  endfunction

  function automatic logic [CMD_W-1:0] pick_cmd();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 18) return CMD_MAP;
    if (r < 26) return CMD_UNMAP;
    if (r < 44) return CMD_TRANSLATE;
    if (r < 60) return CMD_READ;
    if (r < 68) return CMD_SET_REF;
    if (r < 76) return CMD_SET_DIRTY;
    if (r < 84) return CMD_CLR_REF;
    if (r < 86) return CMD_CLEAR_ALL;
    if (r < 92) return CMD_COUNT;
    return CMD_W'($urandom_range(CMD_COUNT + 1, 15));
  endfunction

  task automatic random_step(bit idle);
    int unsigned bound;
    int unsigned page;
    int unsigned n;
    bound = mirror.page_bound();
    if (bound > 0 && $urandom_range(0, 1) == 0) begin
      page = (bound < 24) ? $urandom_range(0, bound - 1) : $urandom_range(0, 23);
      send(make_cmd(CMD_MAP, page, $urandom_range(0, 65535), 1'($urandom_range(0, 1))),
           idle);
      n = $urandom_range(1, 4);
      repeat (n) begin
        send(make_cmd(CMD_W'($urandom_range(CMD_TRANSLATE, CMD_CLR_REF)), page,
                      $urandom_range(0, 65535), 1'($urandom_range(0, 1))), idle);
      end
      if ($urandom_range(0, 9) < 3) begin
        send(make_cmd(CMD_UNMAP, page, $urandom_range(0, 65535), 1'b0), idle);
        send(make_cmd(CMD_TRANSLATE, page, 0, 1'b1), idle);
      end
    end else begin
      send(make_cmd(pick_cmd(), pick_page(bound), $urandom_range(0, 65535),
                    1'($urandom_range(0, 1))), idle);
    end
  endtask

  initial begin
    logic [TALLY_W-1:0] settings[8];
    int unsigned        phase_end;
    bit                 idle;
    settings = '{9'd511, 9'd0, 9'd1, 9'd300, 9'd16, 9'd255, 9'd64, 9'd256};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Every entry is written once, then dropped by a clear, so that no read
    // ever returns store content that was never written.
    for (int i = 0; i < PAGE_SLOTS_DEF; i++) begin
      send(make_cmd(CMD_MAP, i, $urandom_range(0, 65535), 1'b0), 1'b0);
    end
    send(make_cmd(CMD_CLEAR_ALL, 0, 0, 1'b0), 1'b0);

    send(make_cmd(CMD_MAP, 0, 16'hFFFF, 1'b0), 1'b0);
    send(make_cmd(CMD_READ, 0, 0, 1'b0), 1'b0);
    send(make_cmd(CMD_TRANSLATE, 0, 0, 1'b0), 1'b0);
    send(make_cmd(CMD_TRANSLATE, 5, 0, 1'b0), 1'b0);
    send(make_cmd(CMD_READ, 5, 0, 1'b0), 1'b0);
    send(make_cmd(CMD_MAP, 255, 16'h0000, 1'b1), 1'b0);
    send(make_cmd(CMD_MAP, 0, 16'h1234, 1'b0), 1'b0);
    send(make_cmd(CMD_SET_DIRTY, 0, 0, 1'b1), 1'b0);
    send(make_cmd(CMD_SET_REF, 0, 0, 1'b0), 1'b0);
    send(make_cmd(CMD_READ, 0, 0, 1'b0), 1'b0);
    send(make_cmd(CMD_CLR_REF, 255, 0, 1'b0), 1'b0);
    send(make_cmd(CMD_READ, 255, 0, 1'b0), 1'b0);
    send(make_cmd(CMD_SET_DIRTY, 7, 0, 1'b1), 1'b0);
    send(make_cmd(CMD_SET_REF, 7, 0, 1'b1), 1'b0);
    send(make_cmd(CMD_READ, 7, 0, 1'b0), 1'b0);
    send(make_cmd(CMD_UNMAP, 0, 0, 1'b0), 1'b0);
    send(make_cmd(CMD_UNMAP, 0, 0, 1'b0), 1'b0);
    send(make_cmd(CMD_MAP, 256, 16'hFFFF, 1'b1), 1'b0);
    send(make_cmd(CMD_TRANSLATE, 16'hFFFF, 0, 1'b0), 1'b0);
    send(make_cmd(CMD_COUNT, 16'hFFFF, 16'hFFFF, 1'b1), 1'b0);
    send(make_cmd(4'd15, 16'hAAAA, 16'h5555, 1'b1), 1'b0);
    send(make_cmd(4'd9, 3, 3, 1'b0), 1'b0);
    send(make_cmd(CMD_CLEAR_ALL, 16'h8000, 0, 1'b1), 1'b0);
    send(make_cmd(CMD_READ, 255, 0, 1'b0), 1'b0);
    send(make_cmd(CMD_COUNT, 0, 0, 1'b0), 1'b0);

    foreach (settings[p]) begin
      write_pages(settings[p]);
      phase_end = issued + 140;
      while (issued < phase_end) begin
        idle = (p != 7) && ((issued / 50) % 3 != 2);
        random_step(idle);
      end
    end

    drain();
    repeat (4) @(posedge clk);
    if (mirror.mismatches == 0 && mirror.outstanding() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
